>>> src/sscf_pkg.sv
// ----------------------------------------------------------------------------
// Sieve survivor coprime filter package
// Shared codes, field widths and the control record that travels down the
// cell chain together with each transaction.
// ----------------------------------------------------------------------------
package sscf_pkg;

    localparam int OP_W      = 2;
    localparam int POS_W     = 16;
    localparam int NORM_W    = 8;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int LOGW_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TEST  = 2'd2
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_SIDE0    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_SIDE1    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_LINE_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_IS_EVEN   = 2'd3;

    localparam logic [NORM_W-1:0]  REJECT_BYTE     = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 17'h1FFFF;
    localparam logic [LOGW_W-1:0]  LOG_WIDTH_RESET = 5'd16;

    typedef struct packed {
        logic              vld;
        t_op               op;
        logic              pass;
        logic              wr;
        logic [NORM_W-1:0] s0;
        logic [COUNT_W-1:0] count;
    } t_ctl;

endpackage

>>> src/sscf_if.sv
// ----------------------------------------------------------------------------
// Sieve survivor coprime filter channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface sscf_in_if import sscf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic [NORM_W-1:0] norm_side0;
    logic [NORM_W-1:0] norm_side1;
    logic [WORD_W-1:0] divisor_inverse;
    logic [WORD_W-1:0] divisor_limit;

    modport source (
        output valid, operation, position, norm_side0, norm_side1,
               divisor_inverse, divisor_limit,
        input  ready
    );
    modport sink (
        input  valid, operation, position, norm_side0, norm_side1,
               divisor_inverse, divisor_limit,
        output ready
    );
endinterface

interface sscf_out_if import sscf_pkg::*;;
    logic               valid;
    logic               ready;
    logic               survived;
    logic [NORM_W-1:0]  new_norm_side0;
    logic [COUNT_W-1:0] survivor_count;

    modport source (
        output valid, survived, new_norm_side0, survivor_count,
        input  ready
    );
    modport sink (
        input  valid, survived, new_norm_side0, survivor_count,
        output ready
    );
endinterface

interface sscf_cfg_if import sscf_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> src/sscf_front.sv
// ----------------------------------------------------------------------------
// Sieve survivor coprime filter entry stage
// Holds the configuration registers, the divisor count and the survivor
// counter, and launches each transaction into the cell chain.
// ----------------------------------------------------------------------------
module sscf_front import sscf_pkg::*; #(
    parameter int MAX_DIVISORS  = 6,
    parameter int MAX_LOG_WIDTH = 16,
    parameter int IW            = 16,
    parameter int CW            = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    sscf_in_if.sink           i_in,
    sscf_cfg_if.sink          i_cfg,
    output t_ctl              o_ctl,
    output logic [IW-1:0]     o_i,
    output logic [CW-1:0]     o_tag,
    output logic [WORD_W-1:0] o_inv,
    output logic [WORD_W-1:0] o_lim
);

    logic [NORM_W-1:0]  r_bound0;
    logic [NORM_W-1:0]  r_bound1;
    logic [LOGW_W-1:0]  r_logw;
    logic               r_even;
    logic [CW-1:0]      r_div;
    logic [COUNT_W-1:0] r_surv;
    t_ctl               r_ctl;
    logic [IW-1:0]      r_i;
    logic [CW-1:0]      r_tag;
    logic [WORD_W-1:0]  r_inv;
    logic [WORD_W-1:0]  r_lim;

    logic [CW-1:0]      n_div;
    logic [COUNT_W-1:0] n_surv;
    t_ctl               n_ctl;
    logic [IW-1:0]      n_i;
    logic [LOGW_W-1:0]  w_lw;
    logic [IW-1:0]      w_half;
    logic [IW-1:0]      w_x;
    logic               w_pass;
    logic               w_acc;

    assign i_in.ready  = i_adv;
    assign i_cfg.ready = 1'b1;
    assign w_acc       = i_in.valid & i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound0 <= '0;
            r_bound1 <= '0;
            r_logw   <= LOG_WIDTH_RESET;
            r_even   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BOUND_SIDE0:    r_bound0 <= i_cfg.data;
                CFG_BOUND_SIDE1:    r_bound1 <= i_cfg.data;
                CFG_LOG_LINE_WIDTH: r_logw   <= i_cfg.data[LOGW_W-1:0];
                CFG_LINE_IS_EVEN:   r_even   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_lw = r_logw;
        if (r_logw < LOGW_W'(1)) begin
            w_lw = LOGW_W'(1);
        end else if (r_logw > LOGW_W'(MAX_LOG_WIDTH)) begin
            w_lw = LOGW_W'(MAX_LOG_WIDTH);
        end
        w_half = IW'(1) << (w_lw - LOGW_W'(1));
        w_x    = IW'(i_in.position);
        n_i    = (w_x >= w_half) ? (w_x - w_half) : (w_half - w_x);
    end

    assign w_pass = (i_in.norm_side0 != REJECT_BYTE) &&
                    (i_in.norm_side0 <= r_bound0) &&
                    (i_in.norm_side1 <= r_bound1) &&
                    !(r_even && !i_in.position[0]);

    always_comb begin
        n_div  = r_div;
        n_surv = r_surv;
        n_ctl.vld   = i_in.valid;
        n_ctl.op    = t_op'(i_in.operation);
        n_ctl.pass  = w_pass;
        n_ctl.wr    = 1'b0;
        n_ctl.s0    = i_in.norm_side0;
        case (t_op'(i_in.operation))
            OP_START: begin
                n_div  = '0;
                n_surv = '0;
            end
            OP_LOAD: begin
                if (r_div < CW'(MAX_DIVISORS)) begin
                    n_ctl.wr = 1'b1;
                    n_div    = r_div + CW'(1);
                end
            end
            OP_TEST: begin
                if (w_pass && (r_surv != COUNT_MAX)) begin
                    n_surv = r_surv + COUNT_W'(1);
                end
            end
            default: ;
        endcase
        n_ctl.count = n_surv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div     <= '0;
            r_surv    <= '0;
            r_ctl.vld <= 1'b0;
        end else begin
            if (w_acc) begin
                r_div  <= n_div;
                r_surv <= n_surv;
            end
            if (i_adv) begin
                r_ctl <= n_ctl;
                r_i   <= n_i;
                r_tag <= r_div;
                r_inv <= i_in.divisor_inverse;
                r_lim <= i_in.divisor_limit;
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_i   = r_i;
    assign o_tag = r_tag;
    assign o_inv = r_inv;
    assign o_lim = r_lim;

endmodule

>>> src/sscf_cell.sv
// ----------------------------------------------------------------------------
// Sieve survivor coprime filter divisor cell
// Holds one divisor pair, captures it from a passing load, and for a passing
// test settles the previous cell's product while forming its own.
// ----------------------------------------------------------------------------
module sscf_cell import sscf_pkg::*; #(
    parameter int K  = 0,
    parameter int IW = 16,
    parameter int CW = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_ctl              i_ctl,
    input  logic [IW-1:0]     i_i,
    input  logic [CW-1:0]     i_tag,
    input  logic [WORD_W-1:0] i_inv,
    input  logic [WORD_W-1:0] i_lim,
    input  logic              i_hit,
    input  logic              i_use,
    input  logic [WORD_W-1:0] i_prod,
    input  logic [WORD_W-1:0] i_plim,
    output t_ctl              o_ctl,
    output logic [IW-1:0]     o_i,
    output logic [CW-1:0]     o_tag,
    output logic [WORD_W-1:0] o_inv,
    output logic [WORD_W-1:0] o_lim,
    output logic              o_hit,
    output logic              o_use,
    output logic [WORD_W-1:0] o_prod,
    output logic [WORD_W-1:0] o_plim
);

    logic [WORD_W-1:0]    r_inverse;
    logic [WORD_W-1:0]    r_limit;
    t_ctl                 r_ctl;
    logic [IW-1:0]        r_i;
    logic [CW-1:0]        r_tag;
    logic [WORD_W-1:0]    r_inv;
    logic [WORD_W-1:0]    r_lim;
    logic                 r_hit;
    logic                 r_use;
    logic [WORD_W-1:0]    r_prod;
    logic [WORD_W-1:0]    r_plim;

    logic [IW+WORD_W-1:0] w_full;
    logic                 w_write;

    assign w_full  = {{WORD_W{1'b0}}, i_i} * {{IW{1'b0}}, r_inverse};
    assign w_write = i_adv && i_ctl.vld && (i_ctl.op == OP_LOAD) && i_ctl.wr &&
                     (i_tag == CW'(K));

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_inverse <= i_inv;
            r_limit   <= i_lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else if (i_adv) begin
            r_ctl  <= i_ctl;
            r_i    <= i_i;
            r_tag  <= i_tag;
            r_inv  <= i_inv;
            r_lim  <= i_lim;
            r_hit  <= i_hit | (i_use & (i_prod <= i_plim));
            r_use  <= (i_ctl.op == OP_TEST) && (CW'(K) < i_tag);
            r_prod <= w_full[WORD_W-1:0];
            r_plim <= r_limit;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_i    = r_i;
    assign o_tag  = r_tag;
    assign o_inv  = r_inv;
    assign o_lim  = r_lim;
    assign o_hit  = r_hit;
    assign o_use  = r_use;
    assign o_prod = r_prod;
    assign o_plim = r_plim;

endmodule

>>> src/sscf_tail.sv
// ----------------------------------------------------------------------------
// Sieve survivor coprime filter result stage
// Settles the last cell's product, forms the result and holds it in the
// output register; its occupancy sets the advance of the whole chain.
// ----------------------------------------------------------------------------
module sscf_tail import sscf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic              i_hit,
    input  logic              i_use,
    input  logic [WORD_W-1:0] i_prod,
    input  logic [WORD_W-1:0] i_plim,
    output logic              o_adv,
    sscf_out_if.source        o_out
);

    logic               r_valid;
    logic               r_survived;
    logic [NORM_W-1:0]  r_norm;
    logic [COUNT_W-1:0] r_count;

    logic               w_hit;
    logic               w_test;
    logic               w_surv;

    assign o_adv  = !r_valid || o_out.ready;
    assign w_hit  = i_hit || (i_use && (i_prod <= i_plim));
    assign w_test = (i_ctl.op == OP_TEST);
    assign w_surv = w_test && i_ctl.pass && !w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid    <= i_ctl.vld;
            r_survived <= w_surv;
            r_norm     <= w_surv ? i_ctl.s0 : (w_test ? REJECT_BYTE : '0);
            r_count    <= i_ctl.count;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.survived       = r_survived;
    assign o_out.new_norm_side0 = r_norm;
    assign o_out.survivor_count = r_count;

endmodule

>>> src/sieve_survivor_coprime_filter_core.sv
// ----------------------------------------------------------------------------
// Sieve survivor coprime filter core
// Filters one sieve line cell by cell against up to MAX_DIVISORS loaded
// divisor pairs, held one per cell in a chain that every transaction walks.
//
//   Channel  Direction  Transaction
//   i_in     sink       start line, load divisor pair or test cell
//   o_out    source     one result per input transaction
//   i_cfg    sink       write of one configuration register, always ready
//
// One transaction is accepted per cycle while o_out is not stalled; its result
// passes the entry register, which the accepting edge loads, then one register
// per divisor cell and the output register before it is offered.
// Each cell runs one multiply and one compare per cycle while the chain advances.
// Reset is synchronous and clears the counters and the valid bits of the chain.
// A stall on o_out freezes the whole chain, and i_in.ready follows it.
// ----------------------------------------------------------------------------
module sieve_survivor_coprime_filter_core import sscf_pkg::*; #(
    parameter int MAX_DIVISORS  = 6,
    parameter int MAX_LOG_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sscf_in_if.sink    i_in,
    sscf_cfg_if.sink   i_cfg,
    sscf_out_if.source o_out
);

    localparam int IW = (MAX_LOG_WIDTH > POS_W) ? MAX_LOG_WIDTH : POS_W;
    localparam int CW = $clog2(MAX_DIVISORS + 1);

    logic              w_adv;
    t_ctl              w_ctl  [0:MAX_DIVISORS];
    logic [IW-1:0]     w_i    [0:MAX_DIVISORS];
    logic [CW-1:0]     w_tag  [0:MAX_DIVISORS];
    logic [WORD_W-1:0] w_inv  [0:MAX_DIVISORS];
    logic [WORD_W-1:0] w_lim  [0:MAX_DIVISORS];
    logic              w_hit  [0:MAX_DIVISORS];
    logic              w_use  [0:MAX_DIVISORS];
    logic [WORD_W-1:0] w_prod [0:MAX_DIVISORS];
    logic [WORD_W-1:0] w_plim [0:MAX_DIVISORS];

    sscf_front #(
        .MAX_DIVISORS  (MAX_DIVISORS),
        .MAX_LOG_WIDTH (MAX_LOG_WIDTH),
        .IW            (IW),
        .CW            (CW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_ctl   (w_ctl[0]),
        .o_i     (w_i[0]),
        .o_tag   (w_tag[0]),
        .o_inv   (w_inv[0]),
        .o_lim   (w_lim[0])
    );

    assign w_hit[0]  = 1'b0;
    assign w_use[0]  = 1'b0;
    assign w_prod[0] = '0;
    assign w_plim[0] = '0;

    for (genvar k = 0; k < MAX_DIVISORS; k++) begin : g_cell
        sscf_cell #(
            .K  (k),
            .IW (IW),
            .CW (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctl   (w_ctl[k]),
            .i_i     (w_i[k]),
            .i_tag   (w_tag[k]),
            .i_inv   (w_inv[k]),
            .i_lim   (w_lim[k]),
            .i_hit   (w_hit[k]),
            .i_use   (w_use[k]),
            .i_prod  (w_prod[k]),
            .i_plim  (w_plim[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_i     (w_i[k+1]),
            .o_tag   (w_tag[k+1]),
            .o_inv   (w_inv[k+1]),
            .o_lim   (w_lim[k+1]),
            .o_hit   (w_hit[k+1]),
            .o_use   (w_use[k+1]),
            .o_prod  (w_prod[k+1]),
            .o_plim  (w_plim[k+1])
        );
    end

    sscf_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl[MAX_DIVISORS]),
        .i_hit   (w_hit[MAX_DIVISORS]),
        .i_use   (w_use[MAX_DIVISORS]),
        .i_prod  (w_prod[MAX_DIVISORS]),
        .i_plim  (w_plim[MAX_DIVISORS]),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

endmodule

>>> src/sscf_checker.sv
// ----------------------------------------------------------------------------
// Sieve survivor coprime filter port checker
// Watches the ports of the core for result and flow control consistency.
// ----------------------------------------------------------------------------
module sscf_checker import sscf_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_out_survived,
    input logic [NORM_W-1:0]  i_out_norm,
    input logic [COUNT_W-1:0] i_out_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_survived) &&
            $stable(i_out_norm) && $stable(i_out_count))
        else $error("Result changed while stalled.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Input stalled while the output register is empty.");

    a_survivor_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_survived |-> i_out_norm != REJECT_BYTE)
        else $error("Survivor carries the reject byte.");

    a_survivor_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_survived |-> i_out_count != '0)
        else $error("Survivor reported with an empty survivor count.");

    a_reject_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_survived |-> (i_out_norm == REJECT_BYTE) ||
            (i_out_norm == '0))
        else $error("Non-survivor carries a norm byte other than reject or zero.");

endmodule

bind sieve_survivor_coprime_filter_core sscf_checker u_sscf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_survived (o_out.survived),
    .i_out_norm     (o_out.new_norm_side0),
    .i_out_count    (o_out.survivor_count)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Sieve survivor coprime filter testbench
// Drives start, load and test transactions into the filter core and checks
// each result against a predictor of the line state, the divisor table and
// the survivor counter. A directed table comes first. Random lines under
// several register settings follow.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sscf_pkg::*;

    localparam int MAX_DIV      = 6;
    localparam int MAX_LOG_W    = 16;
    localparam int PIPE_LATENCY = MAX_DIV + 2;
    localparam int N_DIRECTED   = 30;
    localparam int N_SETTINGS   = 7;
    localparam int PHASE_ITEMS  = 105;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [NORM_W-1:0] s0;
        logic [NORM_W-1:0] s1;
        logic [WORD_W-1:0] inv;
        logic [WORD_W-1:0] lim;
    } t_sieve_item;

    typedef struct packed {
        logic               survived;
        logic [NORM_W-1:0]  norm0;
        logic [COUNT_W-1:0] count;
    } t_cell_result;

    typedef enum bit {ROW_ITEM, ROW_REG} t_row_kind;

    // A register row carries the register index in code and the value in s0.
    typedef struct {
        t_row_kind         kind;
        logic [1:0]        code;
        logic [POS_W-1:0]  pos;
        logic [NORM_W-1:0] s0;
        logic [NORM_W-1:0] s1;
        logic [WORD_W-1:0] inv;
        logic [WORD_W-1:0] lim;
        bit                checked;
        t_cell_result      want;
    } t_row;

    typedef struct {
        logic [CFG_DAT_W-1:0] b0;
        logic [CFG_DAT_W-1:0] b1;
        logic [CFG_DAT_W-1:0] lw;
        logic [CFG_DAT_W-1:0] even;
    } t_setting;

    logic i_clk;
    logic i_rst_n;

    sscf_in_if  in_if ();
    sscf_out_if out_if ();
    sscf_cfg_if cfg_if ();

    sieve_survivor_coprime_filter_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    logic [NORM_W-1:0]  cfg_bound0 = '0;
    logic [NORM_W-1:0]  cfg_bound1 = '0;
    logic [LOGW_W-1:0]  cfg_logw   = LOG_WIDTH_RESET;
    logic               cfg_even   = 1'b0;
    logic [WORD_W-1:0]  inv_tab [MAX_DIV];
    logic [WORD_W-1:0]  lim_tab [MAX_DIV];
    int                 div_used = 0;
    logic [COUNT_W-1:0] line_survivors = '0;

    t_cell_result result_q [$];
    int mismatches    = 0;
    int items_sent    = 0;
    bit idling_on     = 1'b1;
    bit long_hold_req = 1'b0;

    int small_primes [15] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};

    t_row directed_rows [N_DIRECTED] = '{
        '{ROW_ITEM, OP_TEST,  16'h8000, 8'h00, 8'h00, 32'h0, 32'h0, 1'b1, '{1'b1, 8'h00, 17'd1}},
        '{ROW_ITEM, OP_TEST,  16'h0000, 8'h00, 8'h01, 32'h0, 32'h0, 1'b1, '{1'b0, 8'hFF, 17'd1}},
        '{ROW_ITEM, OP_TEST,  16'h0001, 8'hFF, 8'h00, 32'h0, 32'h0, 1'b1, '{1'b0, 8'hFF, 17'd1}},
        '{ROW_ITEM, OP_START, 16'h0000, 8'h00, 8'h00, 32'h0, 32'h0, 1'b1, '{1'b0, 8'h00, 17'd0}},
        '{ROW_REG,  CFG_BOUND_SIDE0,    16'h0, 8'd254, 8'h0, 32'h0, 32'h0, 1'b0, '0},
        '{ROW_REG,  CFG_BOUND_SIDE1,    16'h0, 8'd254, 8'h0, 32'h0, 32'h0, 1'b0, '0},
        '{ROW_REG,  CFG_LOG_LINE_WIDTH, 16'h0, 8'd4,   8'h0, 32'h0, 32'h0, 1'b0, '0},
        '{ROW_REG,  CFG_LINE_IS_EVEN,   16'h0, 8'd1,   8'h0, 32'h0, 32'h0, 1'b0, '0},
        '{ROW_ITEM, OP_TEST,  16'h0001, 8'hFE, 8'hFE, 32'h0, 32'h0, 1'b1, '{1'b1, 8'hFE, 17'd1}},
        '{ROW_ITEM, OP_TEST,  16'h0003, 8'h00, 8'hFF, 32'h0, 32'h0, 1'b1, '{1'b0, 8'hFF, 17'd1}},
        '{ROW_ITEM, OP_TEST,  16'h0002, 8'h00, 8'h00, 32'h0, 32'h0, 1'b1, '{1'b0, 8'hFF, 17'd1}},
        '{ROW_ITEM, OP_LOAD,  16'h0000, 8'h00, 8'h00, 32'hAAAAAAAB, 32'h55555555, 1'b1,
          '{1'b0, 8'h00, 17'd1}},
        '{ROW_ITEM, OP_LOAD,  16'h0000, 8'h00, 8'h00, 32'hCCCCCCCD, 32'h33333333, 1'b1,
          '{1'b0, 8'h00, 17'd1}},
        '{ROW_ITEM, OP_TEST,  16'h000B, 8'h80, 8'h00, 32'h0, 32'h0, 1'b1, '{1'b0, 8'hFF, 17'd2}},
        '{ROW_ITEM, OP_TEST,  16'h000D, 8'h80, 8'h00, 32'h0, 32'h0, 1'b1, '{1'b0, 8'hFF, 17'd3}},
        '{ROW_ITEM, OP_TEST,  16'h0009, 8'h80, 8'h7F, 32'h0, 32'h0, 1'b1, '{1'b1, 8'h80, 17'd4}},
        '{ROW_ITEM, OP_TEST,  16'hFFFF, 8'h7F, 8'h80, 32'h0, 32'h0, 1'b0, '0},
        '{ROW_ITEM, OP_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
          '{1'b0, 8'h00, 17'd5}},
        '{ROW_ITEM, OP_LOAD,  16'h0000, 8'h00, 8'h00, 32'hB6DB6DB7, 32'h24924924, 1'b1,
          '{1'b0, 8'h00, 17'd5}},
        '{ROW_ITEM, OP_LOAD,  16'h0000, 8'h00, 8'h00, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
          '{1'b0, 8'h00, 17'd5}},
        '{ROW_ITEM, OP_LOAD,  16'h0000, 8'h00, 8'h00, 32'h00000000, 32'h00000000, 1'b1,
          '{1'b0, 8'h00, 17'd5}},
        '{ROW_ITEM, OP_LOAD,  16'h0000, 8'h00, 8'h00, 32'hBA2E8BA3, 32'h1745D174, 1'b1,
          '{1'b0, 8'h00, 17'd5}},
        '{ROW_ITEM, OP_LOAD,  16'h0000, 8'h00, 8'h00, 32'hC4EC4EC5, 32'h13B13B13, 1'b1,
          '{1'b0, 8'h00, 17'd5}},
        '{ROW_ITEM, OP_TEST,  16'h0007, 8'h00, 8'h00, 32'h0, 32'h0, 1'b1, '{1'b0, 8'hFF, 17'd6}},
        '{ROW_REG,  CFG_LOG_LINE_WIDTH, 16'h0, 8'd0, 8'h0, 32'h0, 32'h0, 1'b0, '0},
        '{ROW_ITEM, OP_START, 16'h0000, 8'h00, 8'h00, 32'h0, 32'h0, 1'b1, '{1'b0, 8'h00, 17'd0}},
        '{ROW_ITEM, OP_TEST,  16'h0001, 8'h01, 8'h01, 32'h0, 32'h0, 1'b1, '{1'b1, 8'h01, 17'd1}},
        '{ROW_REG,  CFG_LOG_LINE_WIDTH, 16'h0, 8'd31, 8'h0, 32'h0, 32'h0, 1'b0, '0},
        '{ROW_ITEM, OP_TEST,  16'h0001, 8'h02, 8'h02, 32'h0, 32'h0, 1'b1, '{1'b1, 8'h02, 17'd2}},
        '{ROW_ITEM, OP_START, 16'h0000, 8'h00, 8'h00, 32'h0, 32'h0, 1'b1, '{1'b0, 8'h00, 17'd0}}
    };

    t_setting settings [N_SETTINGS] = '{
        '{8'd254, 8'd254, 8'd16, 8'd0},
        '{8'd0,   8'd0,   8'd2,  8'd1},
        '{8'd128, 8'd200, 8'd5,  8'd0},
        '{8'd255, 8'd255, 8'd8,  8'd1},
        '{8'd200, 8'd100, 8'd0,  8'd0},
        '{8'd100, 8'd255, 8'd31, 8'd1},
        '{8'd254, 8'd254, 8'd3,  8'd0}
    };

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int line_half();
        int lw;
        lw = int'(cfg_logw);
        if (lw < 1) lw = 1;
        if (lw > MAX_LOG_W) lw = MAX_LOG_W;
        return 1 << (lw - 1);
    endfunction

    function automatic logic [WORD_W-1:0] inverse_mod32(input logic [WORD_W-1:0] p);
        logic [WORD_W-1:0] x;
        x = p;
        repeat (5) x = x * (32'd2 - p * x);
        return x;
    endfunction

    function automatic t_cell_result filter_cell(input t_sieve_item it);
        t_cell_result      r;
        int                half;
        logic [WORD_W-1:0] cell_offset;
        logic [WORD_W-1:0] prod;
        bit                pass;
        bit                hit;
        r = '0;
        case (it.op)
            OP_START: begin
                div_used       = 0;
                line_survivors = '0;
            end
            OP_LOAD: begin
                if (div_used < MAX_DIV) begin
                    inv_tab[div_used] = it.inv;
                    lim_tab[div_used] = it.lim;
                    div_used++;
                end
            end
            OP_TEST: begin
                half = line_half();
                cell_offset = (int'(it.pos) >= half) ? WORD_W'(int'(it.pos) - half)
                                                     : WORD_W'(half - int'(it.pos));
                pass = (it.s0 != REJECT_BYTE) && (it.s0 <= cfg_bound0) &&
                       (it.s1 <= cfg_bound1) && !(cfg_even && !it.pos[0]);
                r.norm0 = REJECT_BYTE;
                if (pass) begin
                    if (line_survivors != COUNT_MAX) line_survivors++;
                    hit = 1'b0;
                    for (int k = 0; k < div_used; k++) begin
                        prod = cell_offset * inv_tab[k];
                        if (prod <= lim_tab[k]) hit = 1'b1;
                    end
                    if (!hit) begin
                        r.survived = 1'b1;
                        r.norm0    = it.s0;
                    end
                end
            end
            default: ;
        endcase
        r.count = line_survivors;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_item(input t_sieve_item it, input bit use_typed = 1'b0,
                             input t_cell_result typed = '0);
        t_cell_result predicted;
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.operation       <= it.op;
        in_if.position        <= it.pos;
        in_if.norm_side0      <= it.s0;
        in_if.norm_side1      <= it.s1;
        in_if.divisor_inverse <= it.inv;
        in_if.divisor_limit   <= it.lim;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predicted = filter_cell(it);
        result_q.push_back(use_typed ? typed : predicted);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_BOUND_SIDE0:    cfg_bound0 = val;
            CFG_BOUND_SIDE1:    cfg_bound1 = val;
            CFG_LOG_LINE_WIDTH: cfg_logw   = val[LOGW_W-1:0];
            CFG_LINE_IS_EVEN:   cfg_even   = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_setting(input t_setting s);
        wait_idle();
        write_reg(CFG_BOUND_SIDE0, s.b0);
        write_reg(CFG_BOUND_SIDE1, s.b1);
        write_reg(CFG_LOG_LINE_WIDTH, s.lw);
        write_reg(CFG_LINE_IS_EVEN, s.even);
    endtask

    // Some test positions lie a multiple of a loaded prime away from the line
    // center, so that the divisor test fires often.
    task automatic run_line(input int n_loads, input int n_tests);
        t_sieve_item it;
        int          primes_in_line [$];
        int          p;
        int          half;
        int          step;
        it     = t_sieve_item'({$urandom, $urandom, $urandom, $urandom});
        it.op  = OP_START;
        send_item(it);
        for (int k = 0; k < n_loads; k++) begin
            it    = t_sieve_item'({$urandom, $urandom, $urandom, $urandom});
            it.op = OP_LOAD;
            if ($urandom_range(0, 9) != 0) begin
                p      = small_primes[$urandom_range(0, 14)];
                it.inv = inverse_mod32(WORD_W'(p));
                it.lim = 32'hFFFF_FFFF / WORD_W'(p);
                if (k < MAX_DIV) primes_in_line.push_back(p);
            end
            send_item(it);
        end
        for (int k = 0; k < n_tests; k++) begin
            it = t_sieve_item'({$urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(0, 24) == 0) begin
                it.op = OP_W'($urandom_range(0, 3));
            end else begin
                it.op = OP_TEST;
                half  = line_half();
                case ($urandom_range(0, 4))
                    0, 1: it.pos = POS_W'($urandom_range(0, 2 * half - 1));
                    2: begin
                        if (primes_in_line.size() != 0) begin
                            p    = primes_in_line[$urandom_range(0, primes_in_line.size() - 1)];
                            step = p * $urandom_range(0, 8);
                            it.pos = $urandom_range(0, 1) ? POS_W'(half + step)
                                                          : POS_W'(half - step);
                        end
                    end
                    default: ;
                endcase
                case ($urandom_range(0, 9))
                    0: it.s0 = REJECT_BYTE;
                    1, 2: ;
                    default: begin
                        it.s0 = NORM_W'($urandom_range(0, (cfg_bound0 == REJECT_BYTE) ?
                                                           254 : cfg_bound0));
                        it.s1 = NORM_W'($urandom_range(0, cfg_bound1));
                    end
                endcase
            end
            send_item(it);
        end
    endtask

    initial begin : result_drain
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = 90;
            end else if (stall_left == 0 && idling_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_cell_result want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (result_q.size() == 0) begin
                $display("%0t: result transaction with none outstanding, actual %0h %0h %0h",
                         $time, out_if.survived, out_if.new_norm_side0, out_if.survivor_count);
                mismatches++;
            end else begin
                want = result_q.pop_front();
                compare_field("survived", 32'(want.survived), 32'(out_if.survived));
                compare_field("new_norm_side0", 32'(want.norm0), 32'(out_if.new_norm_side0));
                compare_field("survivor_count", 32'(want.count), 32'(out_if.survivor_count));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, result_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        t_sieve_item it;
        int          phase_base;
        int          waited;
        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.operation       = '0;
        in_if.position        = '0;
        in_if.norm_side0      = '0;
        in_if.norm_side1      = '0;
        in_if.divisor_inverse = '0;
        in_if.divisor_limit   = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_REG) begin
                wait_idle();
                write_reg(directed_rows[r].code, directed_rows[r].s0);
            end else begin
                it = '{directed_rows[r].code, directed_rows[r].pos, directed_rows[r].s0,
                       directed_rows[r].s1, directed_rows[r].inv, directed_rows[r].lim};
                send_item(it, directed_rows[r].checked, directed_rows[r].want);
            end
        end

        for (int s = 0; s < N_SETTINGS; s++) begin
            apply_setting(settings[s]);
            idling_on  = (s != N_SETTINGS - 1);
            phase_base = items_sent;
            if (s == 0) long_hold_req = 1'b1;
            while (items_sent - phase_base < PHASE_ITEMS) begin
                run_line(($urandom_range(0, 7) == 0) ? $urandom_range(7, 8)
                                                     : $urandom_range(0, 6),
                         $urandom_range(8, 30));
                if (s == 2 && items_sent - phase_base < 60) wait_idle();
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        waited = 0;
        while (result_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, result_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/sscf_pkg.sv
src/sscf_if.sv
src/sscf_front.sv
src/sscf_cell.sv
src/sscf_tail.sv
src/sieve_survivor_coprime_filter_core.sv
src/sscf_checker.sv
tb/tb_top.sv
